>>> rtl/sh_band4_axis_rotation_macros.svh
// Assertion macros for the band-4 rotation block.
// Used by the top level only.
`ifndef SH_BAND4_AXIS_ROTATION_MACROS_SVH
`define SH_BAND4_AXIS_ROTATION_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SHR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define SHR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/shr_pkg.sv
// Shared types and constants for the band-4 spherical harmonic rotation.
// No dependencies.
`timescale 1ns / 1ps
package shr_pkg;
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int NUM_COEF        = 9;
   localparam int CORDIC_STEPS    = 24;
   localparam int TRIG_W          = 27;   // Q24 sin/cos incl. sign and headroom
   localparam int ENT_W           = 30;   // Q24 matrix entry
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [ENT_W-1:0] UNIT = ENT_W'(24'sd0) + ENT_W'(1 << 24);

   localparam logic [1:0] CMD_X = 2'd0;
   localparam logic [1:0] CMD_Y = 2'd1;
   localparam logic [1:0] CMD_Z = 2'd2;
   localparam logic [1:0] CMD_PASS = 2'd3;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ENT_W-1:0]  ent_type;

   function automatic logic [31:0] arctan(input int i);
      logic [31:0] t [CORDIC_STEPS];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return t[i];
   endfunction
endpackage

>>> rtl/sh_band4_axis_rotation.sv
// Band-4 spherical harmonic rotation about X, Y or Z.
// Path: an accepted item passes the CORDIC pipes, the matrix, the lanes and the output register.
// Throughput: one item per cycle while adv is high; 4 CORDIC pipes and 9 lanes run in parallel.
// The pipe advances when the output register is free or being taken, or its last stage is empty.
// Reset: synchronous, active high; clears the valid bits of all stages.
`timescale 1ns / 1ps
`include "sh_band4_axis_rotation_macros.svh"
module sh_band4_axis_rotation import shr_pkg::*; #(
   parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_command,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle,
   input  logic signed [COEF_WIDTH-1:0] req_coef_0,
   input  logic signed [COEF_WIDTH-1:0] req_coef_1,
   input  logic signed [COEF_WIDTH-1:0] req_coef_2,
   input  logic signed [COEF_WIDTH-1:0] req_coef_3,
   input  logic signed [COEF_WIDTH-1:0] req_coef_4,
   input  logic signed [COEF_WIDTH-1:0] req_coef_5,
   input  logic signed [COEF_WIDTH-1:0] req_coef_6,
   input  logic signed [COEF_WIDTH-1:0] req_coef_7,
   input  logic signed [COEF_WIDTH-1:0] req_coef_8,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_0,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_1,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_2,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_3,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_4,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_5,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_6,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_7,
   output logic signed [COEF_WIDTH-1:0] rsp_rot_8
);
   localparam int TRIG_LAT = CORDIC_STEPS + 1;
   localparam int MAT_LAT  = 2;
   localparam int LANE_LAT = 2;
   localparam int DEPTH    = TRIG_LAT + MAT_LAT + LANE_LAT;

   logic adv;
   logic out_adv;
   logic vld_ff [DEPTH+1];
   logic [1:0] cmd_ff [TRIG_LAT+1];
   logic signed [COEF_WIDTH-1:0] cf_ff [TRIG_LAT+MAT_LAT+1][NUM_COEF];
   logic [31:0] a32;
   logic signed [COEF_WIDTH-1:0] rot [NUM_COEF];
   trig_type sn [1:4];
   trig_type cs [1:4];
   ent_type  m  [NUM_COEF][NUM_COEF];
   logic     out_vld_ff;
   logic signed [COEF_WIDTH-1:0] out_ff [NUM_COEF];

   // Output register loads when free or being taken; the pipe also moves over a bubble.
   assign out_adv   = !out_vld_ff || rsp_ready;
   assign adv       = !vld_ff[DEPTH] || out_adv;
   assign req_ready = adv;
   assign a32       = {req_angle, {(32-ANGLE_WIDTH){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd_ff[0] <= req_command;
         for (int i = 1; i <= TRIG_LAT; i++) cmd_ff[i] <= cmd_ff[i-1];
         cf_ff[0] <= '{req_coef_0, req_coef_1, req_coef_2, req_coef_3, req_coef_4,
                       req_coef_5, req_coef_6, req_coef_7, req_coef_8};
         for (int i = 1; i <= TRIG_LAT+MAT_LAT; i++) cf_ff[i] <= cf_ff[i-1];
      end
   end

   for (genvar k = 1; k <= 4; k++) begin : g_trig
      logic [31:0] th;
      assign th = a32 * 32'(k);
      shr_cordic u_cordic (.clock(clock), .adv(adv), .theta(th),
                           .sin_out(sn[k]), .cos_out(cs[k]));
   end

   // Angle enters the CORDIC with the item; cmd_ff[TRIG_LAT] lines up with sin/cos.
   shr_matrix u_matrix (.clock(clock), .adv(adv), .cmd(cmd_ff[TRIG_LAT]),
                        .s(sn), .c(cs), .m(m));

   for (genvar r = 0; r < NUM_COEF; r++) begin : g_lane
      shr_lane #(.COEF_WIDTH(COEF_WIDTH)) u_lane (
         .clock(clock), .adv(adv), .ent(m[r]),
         .coef(cf_ff[TRIG_LAT+MAT_LAT]), .rot(rot[r]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_adv) begin
         out_vld_ff <= vld_ff[DEPTH];
      end
   end
   always_ff @(posedge clock) begin
      if (out_adv) out_ff <= rot;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_rot_0 = out_ff[0];
   assign rsp_rot_1 = out_ff[1];
   assign rsp_rot_2 = out_ff[2];
   assign rsp_rot_3 = out_ff[3];
   assign rsp_rot_4 = out_ff[4];
   assign rsp_rot_5 = out_ff[5];
   assign rsp_rot_6 = out_ff[6];
   assign rsp_rot_7 = out_ff[7];
   assign rsp_rot_8 = out_ff[8];

   `SHR_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rot_0), "result dropped while stalled")
   `SHR_ASSERT_IMP(a_ready, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")
   `SHR_ASSERT_NXT(a_fill, clock, reset, adv && vld_ff[DEPTH], rsp_valid, "pipe result lost")
endmodule

>>> rtl/shr_cordic.sv
// Pipelined rotation CORDIC: one binary angle in, Q24 sin and cos out.
// Depends on shr_pkg. One angle per cycle while adv is high.
`timescale 1ns / 1ps
module shr_cordic import shr_pkg::*; (
   input  logic            clock,
   input  logic            adv,
   input  logic [31:0]     theta,
   output trig_type        sin_out,
   output trig_type        cos_out
);
   logic signed [33:0] x_ff [CORDIC_STEPS+1];
   logic signed [33:0] y_ff [CORDIC_STEPS+1];
   logic signed [32:0] z_ff [CORDIC_STEPS+1];
   logic               flip_ff [CORDIC_STEPS+1];
   logic [31:0]        th_in;
   logic               fl_in;
   logic signed [33:0] xf, yf;

   always_comb begin
      fl_in = (theta[31:30] == 2'd1) || (theta[31:30] == 2'd2);
      th_in = fl_in ? theta + 32'h80000000 : theta;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= CORDIC_X0;
         y_ff[0] <= '0;
         z_ff[0] <= {th_in[31], th_in};
         flip_ff[0] <= fl_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (adv) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][32]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed({1'b0, arctan(i)});
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed({1'b0, arctan(i)});
            end
         end
      end
   end

   always_comb begin
      xf = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      yf = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_out <= TRIG_W'((yf + 34'sd32) >>> 6);
         cos_out <= TRIG_W'((xf + 34'sd32) >>> 6);
      end
   end
endmodule

>>> rtl/shr_lane.sv
// One output lane: nine entry-by-coefficient products, summed, rounded, saturated.
// Depends on shr_pkg. Two register stages.
`timescale 1ns / 1ps
module shr_lane import shr_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         adv,
   input  ent_type                      ent   [NUM_COEF],
   input  logic signed [COEF_WIDTH-1:0] coef  [NUM_COEF],
   output logic signed [COEF_WIDTH-1:0] rot
);
   localparam int PW = ENT_W + COEF_WIDTH;
   localparam int AW = PW + 4;
   logic signed [PW-1:0] prod_ff [NUM_COEF];
   logic signed [AW-1:0] acc, v;
   localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (COEF_WIDTH-1)) - 1);
   localparam logic signed [AW-1:0] LO = -AW'(64'sd1 <<< (COEF_WIDTH-1));

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_COEF; k++) prod_ff[k] <= ent[k] * coef[k];
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < NUM_COEF; k++) acc = acc + AW'(prod_ff[k]);
      v = (acc + AW'(1 << 23)) >>> 24;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (v > HI)      rot <= COEF_WIDTH'(HI);
         else if (v < LO) rot <= COEF_WIDTH'(LO);
         else             rot <= COEF_WIDTH'(v);
      end
   end
endmodule

>>> rtl/shr_matrix.sv
// Builds the 9x9 Q24 rotation matrix for the chosen axis from the trig values.
// Depends on shr_pkg. Two register stages (combinations, then scaled entries).
`timescale 1ns / 1ps
module shr_matrix import shr_pkg::*; (
   input  logic       clock,
   input  logic       adv,
   input  logic [1:0] cmd,
   input  trig_type   s [1:4],
   input  trig_type   c [1:4],
   output ent_type    m [NUM_COEF][NUM_COEF]
);
   // Distinct trig combinations; each goes to one or more entries.
   localparam int NCMB = 19;
   logic signed [33:0] cmb_ff [NCMB];
   logic signed [33:0] cmb_in [NCMB];
   logic [1:0]         cmd_ff;
   logic signed [33:0] s1, s2, s3, s4, c1, c2, c3, c4;

   function automatic ent_type ent(input logic signed [33:0] v,
                                   input logic signed [31:0] k);
      logic signed [65:0] p;
      p = v * k + 66'sd536870912;
      return ENT_W'(p >>> 30);
   endfunction

   always_comb begin
      s1 = 34'(s[1]); s2 = 34'(s[2]); s3 = 34'(s[3]); s4 = 34'(s[4]);
      c1 = 34'(c[1]); c2 = 34'(c[2]); c3 = 34'(c[3]); c4 = 34'(c[4]);
      cmb_in[0]  = c3 + 7*c1;
      cmb_in[1]  = c3 - c1;
      cmb_in[2]  = s3 - 3*s1;
      cmb_in[3]  = 3*s3 + 7*s1;
      cmb_in[4]  = c4 + 7*c2;
      cmb_in[5]  = c4 - c2;
      cmb_in[6]  = s4 - 2*s2;
      cmb_in[7]  = s4 + 2*s2;
      cmb_in[8]  = s4 + 14*s2;
      cmb_in[9]  = 7*c3 + c1;
      cmb_in[10] = 7*s3 + 3*s1;
      cmb_in[11] = 3*s3 - s1;
      cmb_in[12] = 7*c4 + c2;
      cmb_in[13] = 7*s4 + 2*s2;
      cmb_in[14] = 7*s4 - 2*s2;
      cmb_in[15] = 35*c4 + 20*c2 + 9*34'(UNIT);
      cmb_in[16] = 7*c4 - 4*c2 - 3*34'(UNIT);
      cmb_in[17] = c4 - 4*c2 + 3*34'(UNIT);
      cmb_in[18] = 7*c4 + 4*c2 + 5*34'(UNIT);
   end

   logic signed [33:0] e1, e2, e3, e4;
   always_ff @(posedge clock) begin
      if (adv) begin
         cmb_ff <= cmb_in;
         cmd_ff <= cmd;
      end
   end

   // Extra combinations not in the table above.
   logic signed [33:0] x1, x2, x3, x4;
   always_comb begin
      x1 = 7*34'(c[3]) + 9*34'(c[1]);
      x2 = 9*34'(c[3]) + 7*34'(c[1]);
      x3 = 34'(c[4]) + 4*34'(c[2]) - 5*34'(UNIT);
      x4 = 34'(c[4]) + 28*34'(c[2]) + 35*34'(UNIT);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e1 <= x1; e2 <= x2; e3 <= x3; e4 <= x4;
      end
   end

   // Delay the raw trig values to line up with the combination register.
   trig_type tz_s [1:4];
   trig_type tz_c [1:4];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= 4; k++) begin
            tz_s[k] <= s[k];
            tz_c[k] <= c[k];
         end
      end
   end

   ent_type m_in [NUM_COEF][NUM_COEF];
   always_comb begin
      for (int r = 0; r < NUM_COEF; r++)
         for (int k = 0; k < NUM_COEF; k++) m_in[r][k] = '0;
      case (cmd_ff)
         CMD_X: begin
            m_in[0][0] = ent(cmb_ff[0], 32'sd134217728);
            m_in[0][2] = ent(cmb_ff[1], 32'sd355106730);
            m_in[0][5] = ent(-cmb_ff[2], 32'sd251098377);
            m_in[0][7] = ent(-cmb_ff[3], 32'sd94906266);
            m_in[1][1] = ent(cmb_ff[4], 32'sd134217728);
            m_in[1][3] = ent(cmb_ff[5], 32'sd355106730);
            m_in[1][4] = ent(-cmb_ff[6], 32'sd280736520);
            m_in[1][6] = ent(-cmb_ff[7], 32'sd251098377);
            m_in[1][8] = ent(-cmb_ff[8], 32'sd47453133);
            m_in[2][0] = ent(cmb_ff[1], 32'sd355106730);
            m_in[2][2] = ent(cmb_ff[9], 32'sd134217728);
            m_in[2][5] = ent(-cmb_ff[10], 32'sd94906266);
            m_in[2][7] = ent(-cmb_ff[11], 32'sd251098377);
            m_in[3][1] = ent(cmb_ff[5], 32'sd355106730);
            m_in[3][3] = ent(cmb_ff[12], 32'sd134217728);
            m_in[3][4] = ent(-cmb_ff[13], 32'sd106108431);
            m_in[3][6] = ent(-cmb_ff[14], 32'sd94906266);
            m_in[3][8] = ent(-cmb_ff[6], 32'sd125549188);
            m_in[4][1] = ent(cmb_ff[6], 32'sd280736520);
            m_in[4][3] = ent(cmb_ff[13], 32'sd106108431);
            m_in[4][4] = ent(cmb_ff[15], 32'sd16777216);
            m_in[4][6] = ent(cmb_ff[16], 32'sd75029991);
            m_in[4][8] = ent(cmb_ff[17], 32'sd99255348);
            m_in[5][0] = ent(cmb_ff[2], 32'sd251098377);
            m_in[5][2] = ent(cmb_ff[10], 32'sd94906266);
            m_in[5][5] = ent(e1, 32'sd67108864);
            m_in[5][7] = ent(cmb_ff[1], 32'sd532660095);
            m_in[6][1] = ent(cmb_ff[7], 32'sd251098377);
            m_in[6][3] = ent(cmb_ff[14], 32'sd94906266);
            m_in[6][4] = ent(cmb_ff[16], 32'sd75029991);
            m_in[6][6] = ent(cmb_ff[18], 32'sd67108864);
            m_in[6][8] = ent(e3, 32'sd88776682);
            m_in[7][0] = ent(cmb_ff[3], 32'sd94906266);
            m_in[7][2] = ent(cmb_ff[11], 32'sd251098377);
            m_in[7][5] = ent(cmb_ff[1], 32'sd532660095);
            m_in[7][7] = ent(e2, 32'sd67108864);
            m_in[8][1] = ent(cmb_ff[8], 32'sd47453133);
            m_in[8][3] = ent(cmb_ff[6], 32'sd125549188);
            m_in[8][4] = ent(cmb_ff[17], 32'sd99255348);
            m_in[8][6] = ent(e3, 32'sd88776682);
            m_in[8][8] = ent(e4, 32'sd16777216);
         end
         CMD_Y: begin
            m_in[0][0] = ent(cmb_ff[0], 32'sd134217728);
            m_in[0][1] = ent(cmb_ff[3], 32'sd94906266);
            m_in[0][2] = ent(-cmb_ff[1], 32'sd355106730);
            m_in[0][3] = ent(-cmb_ff[2], 32'sd251098377);
            m_in[1][0] = ent(-cmb_ff[3], 32'sd94906266);
            m_in[1][1] = ent(e2, 32'sd67108864);
            m_in[1][2] = ent(cmb_ff[11], 32'sd251098377);
            m_in[1][3] = ent(-cmb_ff[1], 32'sd532660095);
            m_in[2][0] = ent(-cmb_ff[1], 32'sd355106730);
            m_in[2][1] = ent(-cmb_ff[11], 32'sd251098377);
            m_in[2][2] = ent(cmb_ff[9], 32'sd134217728);
            m_in[2][3] = ent(cmb_ff[10], 32'sd94906266);
            m_in[3][0] = ent(cmb_ff[2], 32'sd251098377);
            m_in[3][1] = ent(-cmb_ff[1], 32'sd532660095);
            m_in[3][2] = ent(-cmb_ff[10], 32'sd94906266);
            m_in[3][3] = ent(e1, 32'sd67108864);
            m_in[4][4] = ent(cmb_ff[15], 32'sd16777216);
            m_in[4][5] = ent(-cmb_ff[13], 32'sd106108431);
            m_in[4][6] = ent(-cmb_ff[16], 32'sd75029991);
            m_in[4][7] = ent(cmb_ff[6], 32'sd280736520);
            m_in[4][8] = ent(cmb_ff[17], 32'sd99255348);
            m_in[5][4] = ent(cmb_ff[13], 32'sd106108431);
            m_in[5][5] = ent(cmb_ff[12], 32'sd134217728);
            m_in[5][6] = ent(-cmb_ff[14], 32'sd94906266);
            m_in[5][7] = ent(-cmb_ff[5], 32'sd355106730);
            m_in[5][8] = ent(cmb_ff[6], 32'sd125549188);
            m_in[6][4] = ent(-cmb_ff[16], 32'sd75029991);
            m_in[6][5] = ent(cmb_ff[14], 32'sd94906266);
            m_in[6][6] = ent(cmb_ff[18], 32'sd67108864);
            m_in[6][7] = ent(-cmb_ff[7], 32'sd251098377);
            m_in[6][8] = ent(-e3, 32'sd88776682);
            m_in[7][4] = ent(-cmb_ff[6], 32'sd280736520);
            m_in[7][5] = ent(-cmb_ff[5], 32'sd355106730);
            m_in[7][6] = ent(cmb_ff[7], 32'sd251098377);
            m_in[7][7] = ent(cmb_ff[4], 32'sd134217728);
            m_in[7][8] = ent(-cmb_ff[8], 32'sd47453133);
            m_in[8][4] = ent(cmb_ff[17], 32'sd99255348);
            m_in[8][5] = ent(-cmb_ff[6], 32'sd125549188);
            m_in[8][6] = ent(-e3, 32'sd88776682);
            m_in[8][7] = ent(cmb_ff[8], 32'sd47453133);
            m_in[8][8] = ent(e4, 32'sd16777216);
         end
         CMD_Z: begin
            m_in[0][0] = ENT_W'(tz_c[4]); m_in[0][8] = ENT_W'(tz_s[4]);
            m_in[8][8] = ENT_W'(tz_c[4]); m_in[8][0] = -ENT_W'(tz_s[4]);
            m_in[1][1] = ENT_W'(tz_c[3]); m_in[1][7] = ENT_W'(tz_s[3]);
            m_in[7][7] = ENT_W'(tz_c[3]); m_in[7][1] = -ENT_W'(tz_s[3]);
            m_in[2][2] = ENT_W'(tz_c[2]); m_in[2][6] = ENT_W'(tz_s[2]);
            m_in[6][6] = ENT_W'(tz_c[2]); m_in[6][2] = -ENT_W'(tz_s[2]);
            m_in[3][3] = ENT_W'(tz_c[1]); m_in[3][5] = ENT_W'(tz_s[1]);
            m_in[5][5] = ENT_W'(tz_c[1]); m_in[5][3] = -ENT_W'(tz_s[1]);
            m_in[4][4] = UNIT;
         end
         default: begin
            for (int r = 0; r < NUM_COEF; r++) m_in[r][r] = UNIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) m <= m_in;
   end
endmodule
